[design/ffwa_pkg.sv]
// Shared types and constants for the first-fit word allocator.
// No dependencies; every other file imports this package.
package ffwa_pkg;

  localparam int SIZE_W  = 13;  // size_bytes field
  localparam int INDEX_W = 10;  // start_index / run_start fields
  localparam int WORDS_W = 11;  // run_words field

  localparam int DEF_WORD_COUNT = 1024;
  localparam int DEF_WORD_BYTES = 4;

  // request opcodes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SIZE_W-1:0]  size_bytes;
    logic [INDEX_W-1:0] start_index;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [INDEX_W-1:0] run_start;
    logic [WORDS_W-1:0] run_words;
  } rsp_t;

endpackage

[design/ffwa_req_if.sv]
// Request channel of the allocator: valid/ready handshake with a req_t payload.
// Depends on ffwa_pkg.
interface ffwa_req_if;
  import ffwa_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/ffwa_rsp_if.sv]
// Result channel of the allocator: valid/ready handshake with an rsp_t payload.
// Depends on ffwa_pkg.
interface ffwa_rsp_if;
  import ffwa_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/first_fit_word_allocator.sv]
// First-fit word allocator. The occupancy map (one bit per word) lives in a
// synchronous single-bit RAM of WORD_COUNT entries with a registered read. After
// reset the block runs a clearing pass over all WORD_COUNT entries, writing one
// entry per cycle, and takes no request until it is done. An allocate request
// scans the map from word 0, one word per cycle with reads issued back to back,
// until it finds a free run long enough for the byte size (rounded up to words),
// then writes the run back one word per cycle. A free request streams from
// start_index, clearing one occupied word per cycle while reading the next,
// until a free word or the last word of the map. The single RAM port pair sets
// the pace of one word per cycle. One request is in flight at a time; a
// finished result sits in an output register, so the next request is taken
// while the result waits for its consumer. Zero size, no fitting run, or a
// free past the map return success=0 with zero fields.
// Depends on ffwa_pkg, ffwa_req_if, ffwa_rsp_if.
module first_fit_word_allocator #(
  parameter int WORD_COUNT = ffwa_pkg::DEF_WORD_COUNT,
  parameter int WORD_BYTES = ffwa_pkg::DEF_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  ffwa_req_if.sink    req,
  ffwa_rsp_if.source  rsp
);
  import ffwa_pkg::*;

  localparam int IW  = $clog2(WORD_COUNT);      // word index
  localparam int CW  = $clog2(WORD_COUNT + 1);  // run length, can equal WORD_COUNT
  localparam int RBW = SIZE_W + 1;              // bytes covered by current run
  localparam logic [IW-1:0] LAST_IDX = IW'(WORD_COUNT - 1);

  // controller states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // post-reset clearing pass
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;  // streaming reads of the map
  localparam logic [2:0] ST_MARK  = 3'd3;  // write back an allocated run
  localparam logic [2:0] ST_POST  = 3'd4;  // hand result to output register

  logic [2:0]     state, state_next;
  logic           mode_q, mode_q_next;
  logic [SIZE_W-1:0] size_q, size_q_next;
  logic [IW-1:0]  rd_idx, rd_idx_next;      // index whose data is in rd_data
  logic [CW-1:0]  run_cnt, run_cnt_next;    // free run length / words cleared
  logic [RBW-1:0] run_bytes, run_bytes_next;
  logic [IW-1:0]  mark_ptr, mark_ptr_next;  // also the clearing pointer
  logic [IW-1:0]  mark_end, mark_end_next;

  logic           pend_ok, pend_ok_next;
  logic [IW-1:0]  pend_start, pend_start_next;
  logic [CW-1:0]  pend_words, pend_words_next;

  logic           out_valid;
  rsp_t           out_data;

  // map RAM
  logic           occ_mem [WORD_COUNT];
  logic           rd_data;
  logic           mem_we, mem_wd, mem_re;
  logic [IW-1:0]  mem_wa, mem_ra;

  logic           accept;
  logic           slot_free;
  logic [CW-1:0]  run_inc;
  logic [RBW-1:0] bytes_inc;
  logic           rd_last;

  function automatic logic [WORDS_W-1:0] sat_words(input logic [CW-1:0] w);
    if (32'(w) > 32'd2047) begin
      return '1;
    end
    return WORDS_W'(w);
  endfunction

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign run_inc   = run_cnt + CW'(1);
  assign bytes_inc = run_bytes + RBW'(WORD_BYTES);
  assign rd_last   = (rd_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= occ_mem[mem_ra];
    end
  end

  always_comb begin
    state_next      = state;
    mode_q_next     = mode_q;
    size_q_next     = size_q;
    rd_idx_next     = rd_idx;
    run_cnt_next    = run_cnt;
    run_bytes_next  = run_bytes;
    mark_ptr_next   = mark_ptr;
    mark_end_next   = mark_end;
    pend_ok_next    = pend_ok;
    pend_start_next = pend_start;
    pend_words_next = pend_words;
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = mark_ptr;
    mem_re = 1'b0;
    mem_ra = rd_idx + IW'(1);

    unique case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mark_ptr_next = mark_ptr + IW'(1);
        if (mark_ptr == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          mode_q_next    = req.data.mode;
          size_q_next    = req.data.size_bytes;
          run_cnt_next   = '0;
          run_bytes_next = '0;
          if (req.data.mode == MODE_ALLOC) begin
            if (req.data.size_bytes == '0) begin
              pend_ok_next    = 1'b0;
              pend_start_next = '0;
              pend_words_next = '0;
              state_next      = ST_POST;
            end else begin
              mem_re      = 1'b1;
              mem_ra      = '0;
              rd_idx_next = '0;
              state_next  = ST_SCAN;
            end
          end else begin
            if (32'(req.data.start_index) >= 32'(WORD_COUNT)) begin
              pend_ok_next    = 1'b0;
              pend_start_next = '0;
              pend_words_next = '0;
              state_next      = ST_POST;
            end else begin
              mem_re          = 1'b1;
              mem_ra          = IW'(req.data.start_index);
              rd_idx_next     = IW'(req.data.start_index);
              pend_start_next = IW'(req.data.start_index);
              state_next      = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (mode_q == MODE_ALLOC) begin
          if (!rd_data) begin
            run_cnt_next   = run_inc;
            run_bytes_next = bytes_inc;
            if (bytes_inc >= RBW'(size_q)) begin
              // run ends here: start = rd_idx - (run_inc - 1)
              pend_ok_next    = 1'b1;
              pend_start_next = rd_idx - IW'(run_cnt);
              pend_words_next = run_inc;
              mark_ptr_next   = rd_idx - IW'(run_cnt);
              mark_end_next   = rd_idx;
              state_next      = ST_MARK;
            end else if (rd_last) begin
              pend_ok_next    = 1'b0;
              pend_start_next = '0;
              pend_words_next = '0;
              state_next      = ST_POST;
            end else begin
              mem_re      = 1'b1;
              rd_idx_next = rd_idx + IW'(1);
            end
          end else begin
            run_cnt_next   = '0;
            run_bytes_next = '0;
            if (rd_last) begin
              pend_ok_next    = 1'b0;
              pend_start_next = '0;
              pend_words_next = '0;
              state_next      = ST_POST;
            end else begin
              mem_re      = 1'b1;
              rd_idx_next = rd_idx + IW'(1);
            end
          end
        end else begin
          pend_ok_next = 1'b1;
          if (rd_data) begin
            // clear this word while the next one is read
            mem_we       = 1'b1;
            mem_wa       = rd_idx;
            mem_wd       = 1'b0;
            run_cnt_next = run_inc;
            if (rd_last) begin
              pend_words_next = run_inc;
              state_next      = ST_POST;
            end else begin
              mem_re      = 1'b1;
              rd_idx_next = rd_idx + IW'(1);
            end
          end else begin
            pend_words_next = run_cnt;
            state_next      = ST_POST;
          end
        end
      end

      ST_MARK: begin
        mem_we        = 1'b1;
        mem_wa        = mark_ptr;
        mem_wd        = 1'b1;
        mark_ptr_next = mark_ptr + IW'(1);
        if (mark_ptr == mark_end) begin
          state_next = ST_POST;
        end
      end

      ST_POST: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      mark_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      mark_ptr <= mark_ptr_next;
      if (state == ST_POST && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_q     <= mode_q_next;
    size_q     <= size_q_next;
    rd_idx     <= rd_idx_next;
    run_cnt    <= run_cnt_next;
    run_bytes  <= run_bytes_next;
    mark_end   <= mark_end_next;
    pend_ok    <= pend_ok_next;
    pend_start <= pend_start_next;
    pend_words <= pend_words_next;
    if (state == ST_POST && slot_free) begin
      out_data.success   <= pend_ok;
      out_data.run_start <= INDEX_W'(pend_start);
      out_data.run_words <= sat_words(pend_words);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("request accepted but controller stayed idle");

  // write-back pointer never passes the end of the found run
  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> mark_ptr <= mark_end)
    else $error("mark pointer beyond run end");

  // a run or cleared count never exceeds the words scanned so far
  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> 32'(run_cnt) <= 32'(rd_idx))
    else $error("run count larger than scan position");

  // results only appear from the hand-off state
  a_result_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_POST)
    else $error("result raised outside hand-off");

  // writes during a scan only ever clear words
  a_scan_writes_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && mem_we |-> !mem_wd && mode_q == MODE_FREE)
    else $error("scan wrote an occupied bit");

endmodule

[tb/ffwa_alloc_checker.sv]
// Scoreboard for first_fit_word_allocator: keeps a shadow occupancy map,
// predicts each result as requests are accepted and compares results in order.
// Depends on ffwa_pkg, ffwa_req_if, ffwa_rsp_if.
module ffwa_alloc_checker #(
  parameter int WORD_COUNT = ffwa_pkg::DEF_WORD_COUNT,
  parameter int WORD_BYTES = ffwa_pkg::DEF_WORD_BYTES
) (
  input  logic clk,
  input  logic rst,
  ffwa_req_if  req,
  ffwa_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import ffwa_pkg::*;

  bit   occ_map [WORD_COUNT];
  rsp_t expected_q [$];
  rsp_t want;
  int   mismatch_total = 0;
  int   results_seen = 0;

  task automatic report_mismatch(string msg);
    mismatch_total++;
    if (mismatch_total <= 30) begin
      $display("[%0t] allocator mismatch, result %0d: %s", $time, results_seen, msg);
    end
  endtask

  // run_words saturates rather than wrapping
  function automatic logic [WORDS_W-1:0] sat_words(int n);
    return (n > 2047) ? WORDS_W'(2047) : WORDS_W'(n);
  endfunction

  function automatic rsp_t predict_alloc(logic [SIZE_W-1:0] size_bytes);
    rsp_t r;
    int   need;
    int   run_len;
    int   first;
    r       = '0;
    need    = (int'(size_bytes) + WORD_BYTES - 1) / WORD_BYTES;
    run_len = 0;
    if (need == 0 || need > WORD_COUNT) return r;
    for (int w = 0; w < WORD_COUNT; w++) begin
      if (occ_map[w]) begin
        run_len = 0;
      end else begin
        run_len++;
        if (run_len == need) begin
          first = w + 1 - need;
          for (int k = first; k <= w; k++) occ_map[k] = 1'b1;
          r.success   = 1'b1;
          r.run_start = INDEX_W'(first);
          r.run_words = sat_words(need);
          return r;
        end
      end
    end
    return r;
  endfunction

  // clears occupied words from the start until a free word or the map end
  function automatic rsp_t predict_free(logic [INDEX_W-1:0] start_index);
    rsp_t r;
    int   w;
    int   cleared;
    r       = '0;
    w       = int'(start_index);
    cleared = 0;
    if (w >= WORD_COUNT) return r;
    while (w < WORD_COUNT && occ_map[w]) begin
      occ_map[w] = 1'b0;
      cleared++;
      w++;
    end
    r.success   = 1'b1;
    r.run_start = start_index;
    r.run_words = sat_words(cleared);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WORD_COUNT; w++) occ_map[w] = 1'b0;
      expected_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        if (req.data.mode == MODE_ALLOC) expected_q.push_back(predict_alloc(req.data.size_bytes));
        else expected_q.push_back(predict_free(req.data.start_index));
      end
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          if (rsp.data.success !== want.success)
            report_mismatch($sformatf("success got %0b expected %0b",
                                      rsp.data.success, want.success));
          if (rsp.data.run_start !== want.run_start)
            report_mismatch($sformatf("run_start got %0d expected %0d",
                                      rsp.data.run_start, want.run_start));
          if (rsp.data.run_words !== want.run_words)
            report_mismatch($sformatf("run_words got %0d expected %0d",
                                      rsp.data.run_words, want.run_words));
        end
      end
    end
    fail_count <= mismatch_total;
    pending    <= expected_q.size();
    checked    <= results_seen;
  end

endmodule

[tb/tb_first_fit_word_allocator.sv]
// Top of the first_fit_word_allocator testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on ffwa_pkg, the two channel
// interfaces, the allocator RTL and ffwa_alloc_checker.
module tb_first_fit_word_allocator;
  import ffwa_pkg::*;

  localparam int WORD_COUNT   = DEF_WORD_COUNT;
  localparam int WORD_BYTES   = DEF_WORD_BYTES;
  localparam int DIRECTED     = 19;
  localparam int RANDOM_ITEMS = 561;
  // worst case per item: full scan plus write-back, sender gap,
  // receiver stall slack; plus the clearing pass after reset; taken 4x over
  localparam int CYCLE_LIMIT  =
    4 * (WORD_COUNT + (DIRECTED + RANDOM_ITEMS) * (2 * WORD_COUNT + 130));

  logic clk = 1'b0;
  logic rst;
  logic rx_ready = 1'b0;

  ffwa_req_if req_ch ();
  ffwa_rsp_if rsp_ch ();

  assign rsp_ch.ready = rx_ready;

  int fail_count;
  int pending;
  int checked;

  first_fit_word_allocator #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BYTES (WORD_BYTES)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ffwa_alloc_checker #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BYTES (WORD_BYTES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Result side back-pressure. The stall rate is redrawn at random intervals:
  // sometimes never stalling, sometimes stalling most cycles.
  // ---------------------------------------------------------------------------
  int stall_pct    = 0;
  int pattern_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 15;
          2:       stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
        pattern_left <= $urandom_range(40, 300);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      rx_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking of live allocations, so that most frees hit real runs. Handshakes
  // are captured at the rising edge and booked at the falling edge, which keeps
  // the list away from the stimulus process that reads it at the rising edge.
  // ---------------------------------------------------------------------------
  logic                took_req  = 1'b0;
  logic                took_rsp  = 1'b0;
  logic                took_mode = MODE_ALLOC;
  rsp_t                took_data = '0;
  logic                mode_q      [$];
  logic [INDEX_W-1:0]  live_starts [$];

  always @(posedge clk) begin
    took_req  <= !rst && req_ch.valid && req_ch.ready;
    took_mode <= req_ch.data.mode;
    took_rsp  <= !rst && rsp_ch.valid && rsp_ch.ready;
    took_data <= rsp_ch.data;
  end

  always @(negedge clk) begin
    if (took_req) mode_q.push_back(took_mode);
    if (took_rsp && mode_q.size() != 0) begin
      if (mode_q.pop_front() == MODE_ALLOC && took_data.success) begin
        live_starts.push_back(took_data.run_start);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request sender: bursts of back-to-back items separated by random gaps.
  // valid stays high across a burst; it is only dropped when a gap starts or the sender waits for a drain.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int alloc_sent = 0;
  int free_sent  = 0;

  task automatic push_request(req_t r);
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 24);
    end
  endtask

  // the unused field of each request carries random bits
  task automatic send_alloc(int unsigned size);
    req_t r;
    r.mode        = MODE_ALLOC;
    r.size_bytes  = SIZE_W'(size);
    r.start_index = INDEX_W'($urandom);
    alloc_sent++;
    push_request(r);
  endtask

  task automatic send_free(int unsigned idx);
    req_t r;
    r.mode        = MODE_FREE;
    r.size_bytes  = SIZE_W'($urandom);
    r.start_index = INDEX_W'(idx);
    free_sent++;
    push_request(r);
  endtask

  // hold the sender until every outstanding result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          sel;
    int          pick;
    int unsigned size;
    int unsigned idx;
    bit          want_free;

    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Word size is 4 bytes, so byte counts map as noted.
    send_alloc(0);           // zero size fails
    send_alloc(1);           // 1 word at 0
    send_alloc(4);           // 1 word at 1
    send_alloc(5);           // rounds up to 2 words at 2
    send_free(0);            // adjacent runs 0..3 freed together
    send_free(0);            // free of a free word: success, nothing cleared
    send_alloc(4096);        // the whole map in one run
    send_alloc(1);           // map full: no fitting run
    send_free(1023);         // last word alone, stops at map end
    send_free(512);          // 512..1022
    send_free(0);            // 0..511
    send_alloc(4097);        // one word more than the map holds
    send_alloc(8191);        // largest size field
    send_alloc(4092);        // 1023 words at 0
    send_alloc(8);           // 2 words do not fit in the one left
    send_alloc(3);           // the last word of the map
    send_free(1023);
    send_free(0);            // 1023 words
    send_free(1023);         // top index on a free word

    wait_drained();

    // Random part: mostly small allocations, frees mostly on known starts.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (live_starts.size() > 16) want_free = ($urandom_range(0, 99) < 60);
      else want_free = ($urandom_range(0, 99) < 30);
      if (want_free) begin
        if (live_starts.size() != 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, live_starts.size() - 1);
          idx  = live_starts[pick];
          live_starts.delete(pick);
        end else begin
          idx = $urandom_range(0, WORD_COUNT - 1);
        end
        send_free(idx);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 3)       size = 0;
        else if (sel < 70) size = $urandom_range(1, 64);
        else if (sel < 90) size = $urandom_range(65, 1024);
        else if (sel < 97) size = $urandom_range(1025, 4096);
        else               size = $urandom_range(4097, 8191);
        send_alloc(size);
      end
    end

    wait_drained();
    // wait out a full scan and write-back, so that a stray late result would show up
    repeat (2 * WORD_COUNT + 16) @(posedge clk);

    $display("Covered %0d requests (%0d allocate, %0d free), %0d results checked,",
             alloc_sent + free_sent, alloc_sent, free_sent, checked);
    $display("with random sender gaps, receiver stalls and three full drains.");
    if (fail_count == 0) begin
      $display("tb_first_fit_word_allocator OK");
    end else begin
      $display("tb_first_fit_word_allocator NOT OK");
    end
    $finish;
  end

  // Watchdog: ends a hung run.
  int cycle_count = 0;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
    $display("tb_first_fit_word_allocator NOT OK");
    $finish;
  end

endmodule
